/* rtl/u16u8_pkg.sv */
`timescale 1ns / 1ps

package u16u8_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [4:0]  SUR_PREFIX   = 5'b11011;    // 0xD800..0xDFFF
  localparam logic [5:0]  LOW_PREFIX   = 6'b110111;   // 0xDC00..0xDFFF
  localparam logic [20:0] SUPP_BASE    = 21'h10000;
  localparam logic [7:0]  LEAD_TWO     = 8'hC0;
  localparam logic [7:0]  LEAD_THREE   = 8'hE0;
  localparam logic [7:0]  LEAD_FOUR    = 8'hF0;
  localparam logic [7:0]  CONT_MARK    = 8'h80;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_input;
  } unit_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       bad_sequence;
    logic       run_last;
    logic       string_done;
  } byte_word_t;

  // One queued job: up to four bytes, sent from index 0 up to last_idx.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            bad;
    logic            done_flag;
  } job_t;

endpackage

/* rtl/u16u8_front.sv */
`timescale 1ns / 1ps

module u16u8_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  unit_valid,
  output logic                  unit_stall,
  input  u16u8_pkg::unit_word_t unit_word,
  input  logic                  q_full,
  output logic                  push,
  output u16u8_pkg::job_t       push_job
);

  logic [9:0]  held_high_bits;
  logic        holding_high;
  logic        string_failed;

  logic        accept;
  logic        is_sur;
  logic        is_low;
  logic        last;
  logic [15:0] cu;
  logic [20:0] cp;
  logic        emit;
  logic        raise_err;
  logic        start_hold;

  assign unit_stall = q_full;
  assign accept     = unit_valid && !q_full;
  assign cu         = unit_word.code_unit;
  assign last       = unit_word.end_of_input;
  assign is_sur     = cu[15:11] == u16u8_pkg::SUR_PREFIX;
  assign is_low     = cu[15:10] == u16u8_pkg::LOW_PREFIX;
  assign cp         = {1'b0, held_high_bits, 10'b0} + {11'b0, cu[9:0]} + u16u8_pkg::SUPP_BASE;

  // Classify the unit and build its byte job.
  always_comb begin
    push_job   = '0;
    emit       = 1'b0;
    raise_err  = 1'b0;
    start_hold = 1'b0;
    priority if (string_failed) begin
      emit = 1'b0;
    end else if (holding_high) begin
      if (!is_low) begin
        raise_err = 1'b1;
      end else begin
        emit = 1'b1;
        push_job.bytes[0] = u16u8_pkg::LEAD_FOUR | {5'b0, cp[20:18]};
        push_job.bytes[1] = u16u8_pkg::CONT_MARK | {2'b0, cp[17:12]};
        push_job.bytes[2] = u16u8_pkg::CONT_MARK | {2'b0, cp[11:6]};
        push_job.bytes[3] = u16u8_pkg::CONT_MARK | {2'b0, cp[5:0]};
        push_job.last_idx = 2'd3;
      end
    end else if (is_sur) begin
      if (is_low || last) begin
        raise_err = 1'b1;
      end else begin
        start_hold = 1'b1;
      end
    end else if (cu[15:7] == 9'd0) begin
      emit = 1'b1;
      push_job.bytes[0] = cu[7:0];
      push_job.last_idx = 2'd0;
    end else if (cu[15:11] == 5'd0) begin
      emit = 1'b1;
      push_job.bytes[0] = u16u8_pkg::LEAD_TWO | {3'b0, cu[10:6]};
      push_job.bytes[1] = u16u8_pkg::CONT_MARK | {2'b0, cu[5:0]};
      push_job.last_idx = 2'd1;
    end else begin
      emit = 1'b1;
      push_job.bytes[0] = u16u8_pkg::LEAD_THREE | {4'b0, cu[15:12]};
      push_job.bytes[1] = u16u8_pkg::CONT_MARK | {2'b0, cu[11:6]};
      push_job.bytes[2] = u16u8_pkg::CONT_MARK | {2'b0, cu[5:0]};
      push_job.last_idx = 2'd2;
    end
    if (raise_err) begin
      emit     = 1'b1;
      push_job = '0;
      push_job.bad = 1'b1;
    end
    push_job.done_flag = raise_err || last;
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_high_bits <= '0;
      holding_high   <= 1'b0;
      string_failed  <= 1'b0;
    end else if (accept) begin
      if (string_failed) begin
        if (last) string_failed <= 1'b0;
      end else if (raise_err) begin
        holding_high   <= 1'b0;
        held_high_bits <= '0;
        string_failed  <= !last;
      end else if (start_hold) begin
        holding_high   <= 1'b1;
        held_high_bits <= cu[9:0];
      end else begin
        holding_high   <= 1'b0;
        held_high_bits <= '0;
      end
    end
  end

  a_fail_no_hold: assert property (@(posedge clk) disable iff (rst)
    !(string_failed && holding_high))
    else $error("failed string still holds a high surrogate");

  a_bad_single: assert property (@(posedge clk) disable iff (rst)
    push && push_job.bad |-> push_job.last_idx == 2'd0 && push_job.done_flag)
    else $error("error job must be one result closing the string");

  a_hold_no_push: assert property (@(posedge clk) disable iff (rst)
    accept && start_hold |-> !push)
    else $error("holding a high surrogate must not emit");

endmodule

/* rtl/u16u8_queue.sv */
`timescale 1ns / 1ps

module u16u8_queue #(
  parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u16u8_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output u16u8_pkg::job_t q_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  u16u8_pkg::job_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = count == CNT_W'(DEPTH);
  assign q_valid = count != '0;
  assign q_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

/* rtl/u16u8_back.sv */
`timescale 1ns / 1ps

module u16u8_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  u16u8_pkg::job_t       q_job,
  output logic                  pop,
  output logic                  byte_valid,
  input  logic                  byte_stall,
  output u16u8_pkg::byte_word_t byte_word
);

  u16u8_pkg::job_t cur_job;
  logic            cur_valid;
  logic [1:0]      idx;

  logic out_load;
  logic cur_done;
  logic cur_load;
  logic at_last;

  assign out_load = !byte_valid || !byte_stall;
  assign at_last  = idx == cur_job.last_idx;
  assign cur_done = cur_valid && out_load && at_last;
  assign cur_load = !cur_valid || cur_done;
  assign pop      = q_valid && cur_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      cur_valid  <= 1'b0;
      idx        <= '0;
    end else begin
      if (out_load) byte_valid <= cur_valid;
      if (cur_load) begin
        cur_valid <= q_valid;
        idx       <= '0;
      end else if (out_load) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cur_load) cur_job <= q_job;
    if (out_load) begin
      byte_word.out_byte     <= cur_job.bytes[idx];
      byte_word.bad_sequence <= cur_job.bad;
      byte_word.run_last     <= at_last;
      byte_word.string_done  <= at_last && cur_job.done_flag;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> idx <= cur_job.last_idx)
    else $error("byte index past end of job");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_word.string_done |-> byte_word.run_last)
    else $error("string end not on last byte of a unit");

  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_word.bad_sequence |-> byte_word.run_last && byte_word.out_byte == 8'd0)
    else $error("error result malformed");

endmodule

/* rtl/utf16_to_utf8_transcoder.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake               Payload
// unit     in         unit_valid/unit_stall   unit_word: code_unit, end_of_input
// byte     out        byte_valid/byte_stall   byte_word: out_byte, bad_sequence,
//                                              run_last, string_done
//
// One code unit is taken each cycle while the job queue has room.
// Bytes leave one per cycle while byte_stall is low, a unit's bytes back to back;
//   the single byte-serializer sets the sustained rate for multi-byte text.
// A unit's job passes the queue slot, the current-job register, then the output register.
// rst is synchronous and clears surrogate state, the queue and the output stage.
// unit_stall rises only when the job queue is full; byte_stall holds the output.

module utf16_to_utf8_transcoder #(
  parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  unit_valid,
  output logic                  unit_stall,
  input  u16u8_pkg::unit_word_t unit_word,
  output logic                  byte_valid,
  input  logic                  byte_stall,
  output u16u8_pkg::byte_word_t byte_word
);

  // Front classifies units and tracks surrogate and failed-string state.
  logic            push;
  u16u8_pkg::job_t push_job;
  logic            q_full;

  // Queue decouples unit intake from byte output.
  logic            pop;
  logic            q_valid;
  u16u8_pkg::job_t q_job;

  u16u8_front u_front (
    .clk        (clk),
    .rst        (rst),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .unit_word  (unit_word),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job)
  );

  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  // Back serializes each job into bytes behind a registered output.
  u16u8_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .pop        (pop),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_word  (byte_word)
  );

endmodule
